[src/bse_pkg.sv]
// shared types, constants and helpers of the burning ship escape-time block
`timescale 1ns / 1ps

package bse_pkg;

	// default raster size
	localparam int WIDTH_DEF  = 1024;
	localparam int HEIGHT_DEF = 1024;

	// field widths
	localparam int PIX_W   = 10;
	localparam int ITER_W  = 12;
	localparam int CLS_W   = 2;
	localparam int COORD_W = 32;
	localparam int PROD_W  = 2 * COORD_W;
	localparam int SAT_IN_W = 48;

	// q8.24 format
	localparam int Q_FRAC = 24;
	localparam int HALF_Q = 1 << (Q_FRAC - 1);
	localparam logic [PROD_W-1:0] ESC_BOUND = PROD_W'(16) << (2 * Q_FRAC);

	// queue between the parts
	localparam int QUEUE_DEPTH = 2;

	// configuration register indexes
	localparam int CFG_ADDR_W = 2;
	localparam logic [CFG_ADDR_W-1:0] REG_INV_SCALE = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_SHIFT_RE  = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_SHIFT_IM  = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_ITER  = 2'd3;

	// register reset values
	localparam logic [COORD_W-1:0] INV_SCALE_RST = 32'd83886;
	localparam logic [ITER_W-1:0]  MAX_ITER_RST  = 12'd100;

	// pixel classes
	localparam logic [CLS_W-1:0] CLS_INTERIOR = 2'd0;
	localparam logic [CLS_W-1:0] CLS_ESC_NOW  = 2'd1;
	localparam logic [CLS_W-1:0] CLS_ESC_LATE = 2'd2;

	// item from the mapping front to the iteration engine
	typedef struct packed {
		logic [PIX_W-1:0]          px;
		logic [PIX_W-1:0]          py;
		logic signed [COORD_W-1:0] cr;
		logic signed [COORD_W-1:0] ci;
	} map_item_t;

	// finished result
	typedef struct packed {
		logic [PIX_W-1:0]  px;
		logic [PIX_W-1:0]  py;
		logic [ITER_W-1:0] count;
		logic [CLS_W-1:0]  cls;
	} res_item_t;

	// clamp a wide signed sum to the q8.24 range
	function automatic logic signed [COORD_W-1:0] sat_coord(
		input logic signed [SAT_IN_W-1:0] v
	);
		logic [SAT_IN_W-COORD_W:0] hi;
		hi = v[SAT_IN_W-1:COORD_W-1];
		if ((&hi) || !(|hi)) begin
			return v[COORD_W-1:0];
		end else if (v[SAT_IN_W-1]) begin
			return {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			return {1'b0, {(COORD_W-1){1'b1}}};
		end
	endfunction

endpackage

[src/bse_queue.sv]
// small first-in first-out queue of packed items
`timescale 1ns / 1ps

module bse_queue #(
	parameter int W     = 8,
	parameter int DEPTH = bse_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[src/bse_front.sv]
// input stage: takes pixels and maps them to the point c
`timescale 1ns / 1ps

module bse_front #(
	parameter int WIDTH  = bse_pkg::WIDTH_DEF,
	parameter int HEIGHT = bse_pkg::HEIGHT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic [bse_pkg::PIX_W-1:0]            pixel_x,
	input  logic [bse_pkg::PIX_W-1:0]            pixel_y,
	input  logic [bse_pkg::COORD_W-1:0]          inv_scale,
	input  logic signed [bse_pkg::COORD_W-1:0]   shift_real,
	input  logic signed [bse_pkg::COORD_W-1:0]   shift_imag,
	input  logic                                 q_full,
	output logic                                 q_push,
	output bse_pkg::map_item_t                   q_item
);

	localparam int LOG_X  = $clog2(WIDTH);
	localparam int LOG_Y  = $clog2(HEIGHT);
	localparam int OFFX_W = ((LOG_X > bse_pkg::PIX_W) ? LOG_X : bse_pkg::PIX_W) + 1;
	localparam int OFFY_W = ((LOG_Y > bse_pkg::PIX_W) ? LOG_Y : bse_pkg::PIX_W) + 1;
	localparam int HALF_X = WIDTH / 2;
	localparam int HALF_Y = HEIGHT / 2;
	localparam int SW     = bse_pkg::SAT_IN_W;

	logic signed [OFFX_W-1:0]               off_x;
	logic signed [OFFY_W-1:0]               off_y;
	logic signed [bse_pkg::COORD_W:0]       scale_s;
	logic signed [OFFX_W+bse_pkg::COORD_W:0] prod_x;
	logic signed [OFFY_W+bse_pkg::COORD_W:0] prod_y;
	logic signed [SW-1:0]                   sum_x;
	logic signed [SW-1:0]                   sum_y;
	logic                                   accept;
	logic                                   v_s1;
	bse_pkg::map_item_t                     item_s1;

	// centred offsets times the reciprocal zoom
	assign off_x   = $signed({{(OFFX_W-bse_pkg::PIX_W){1'b0}}, pixel_x}) - $signed(OFFX_W'(HALF_X));
	assign off_y   = $signed({{(OFFY_W-bse_pkg::PIX_W){1'b0}}, pixel_y}) - $signed(OFFY_W'(HALF_Y));
	assign scale_s = $signed({1'b0, inv_scale});
	assign prod_x  = off_x * scale_s;
	assign prod_y  = off_y * scale_s;
	assign sum_x   = SW'(prod_x) + SW'(shift_real) - SW'(bse_pkg::HALF_Q);
	assign sum_y   = SW'(prod_y) + SW'(shift_imag) - SW'(bse_pkg::HALF_Q);

	assign full   = v_s1 && q_full;
	assign accept = push && !full;
	assign q_push = v_s1 && !q_full;
	assign q_item = item_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.px <= pixel_x;
			item_s1.py <= pixel_y;
			item_s1.cr <= bse_pkg::sat_coord(sum_x);
			item_s1.ci <= bse_pkg::sat_coord(sum_y);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (q_push) begin
			v_s1 <= 1'b0;
		end
	end

endmodule

[src/bse_engine.sv]
// iteration engine: runs the burning ship recurrence on one point at a time
`timescale 1ns / 1ps

module bse_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [bse_pkg::ITER_W-1:0]  max_iter,
	input  logic                        in_valid,
	input  bse_pkg::map_item_t          in_item,
	output logic                        in_pop,
	input  logic                        out_full,
	output logic                        out_push,
	output bse_pkg::res_item_t          out_item
);

	localparam int CW = bse_pkg::COORD_W;
	localparam int PW = bse_pkg::PROD_W;
	localparam int SW = bse_pkg::SAT_IN_W;
	localparam int IW = bse_pkg::ITER_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_EVAL = 4'b0100,
		ST_DONE = 4'b1000
	} eng_state_t;

	eng_state_t           state_q;
	logic signed [CW-1:0] a_q;
	logic signed [CW-1:0] b_q;
	logic signed [CW-1:0] cr_q;
	logic signed [CW-1:0] ci_q;
	logic [PW-1:0]        aa_q;
	logic [PW-1:0]        bb_q;
	logic signed [PW-1:0] ab_q;
	logic [IW-1:0]        cnt_q;
	logic                 chk_q;
	logic [bse_pkg::PIX_W-1:0] px_q;
	logic [bse_pkg::PIX_W-1:0] py_q;

	logic [PW-1:0]        mag;
	logic                 esc;
	logic [IW-1:0]        cnt_inc;
	logic signed [PW-1:0] diff;
	logic signed [PW-1:0] ab_abs;
	logic signed [SW-1:0] re_sum;
	logic signed [SW-1:0] im_sum;
	logic [bse_pkg::CLS_W-1:0] cls;

	// products are those of the point just updated, so they also give the escape test
	assign mag     = aa_q + bb_q;
	assign esc     = chk_q && (mag > bse_pkg::ESC_BOUND);
	assign cnt_inc = cnt_q + IW'(chk_q);
	assign diff    = $signed(aa_q) - $signed(bb_q);
	assign ab_abs  = ab_q[PW-1] ? -ab_q : ab_q;
	assign re_sum  = SW'(diff >>> bse_pkg::Q_FRAC) + SW'(cr_q);
	assign im_sum  = SW'(ab_abs >>> (bse_pkg::Q_FRAC - 1)) + SW'(ci_q);

	always_comb begin
		if (cnt_q == max_iter) begin
			cls = bse_pkg::CLS_INTERIOR;
		end else if (cnt_q != '0) begin
			cls = bse_pkg::CLS_ESC_LATE;
		end else begin
			cls = bse_pkg::CLS_ESC_NOW;
		end
	end

	assign in_pop         = (state_q == ST_IDLE) && in_valid;
	assign out_push       = (state_q == ST_DONE) && !out_full;
	assign out_item.px    = px_q;
	assign out_item.py    = py_q;
	assign out_item.count = cnt_q;
	assign out_item.cls   = cls;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					a_q   <= in_item.cr;
					b_q   <= in_item.ci;
					cr_q  <= in_item.cr;
					ci_q  <= in_item.ci;
					px_q  <= in_item.px;
					py_q  <= in_item.py;
					cnt_q <= '0;
					chk_q <= 1'b0;
				end
			end
			ST_MUL: begin
				aa_q <= PW'(a_q * a_q);
				bb_q <= PW'(b_q * b_q);
				ab_q <= PW'(a_q * b_q);
			end
			ST_EVAL: begin
				if (!esc) begin
					cnt_q <= cnt_inc;
					chk_q <= 1'b1;
					a_q   <= bse_pkg::sat_coord(re_sum);
					b_q   <= bse_pkg::sat_coord(im_sum);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (esc || (cnt_inc == max_iter)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_DONE: begin
					if (!out_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[src/burning_ship_escape_time.sv]
// top level of the burning ship escape-time block
`timescale 1ns / 1ps

// usage
// - pixels enter on a queue-style port: an item is taken when push is high and full is low
// - results leave the same way: the oldest result sits on out_x, out_y, iteration_count
//   and pixel_class while empty is low, and is taken when pop is high
// - configuration is a plain write port (cfg_wr, cfg_addr, cfg_wdata); index 0 inv_scale,
//   1 shift_real, 2 shift_imag, 3 max_iterations; write only while no pixel is in flight
// - the front maps a pixel to c through a register and hands it over a two-entry queue
// - the engine takes one point at a time; each iteration forms the products, then updates
//   the point and tests for escape; the first round adds no count and skips the escape
//   test, and at the limit the last new point leaves untested; the 32x32 products have
//   a state of their own
// - the engine takes no new point until its finished result is in the result queue
// - when pop is held low, results collect in a two-entry queue; the engine then waits
//   with its finished item, the front fills its queue and full rises
// - reset clears all queues and the engine, and loads the register defaults
//   (inv_scale 83886, shifts 0, max_iterations 100)

module burning_ship_escape_time #(
	parameter int WIDTH  = bse_pkg::WIDTH_DEF,
	parameter int HEIGHT = bse_pkg::HEIGHT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [bse_pkg::PIX_W-1:0]         pixel_x,
	input  logic [bse_pkg::PIX_W-1:0]         pixel_y,
	output logic                              empty,
	input  logic                              pop,
	output logic [bse_pkg::PIX_W-1:0]         out_x,
	output logic [bse_pkg::PIX_W-1:0]         out_y,
	output logic [bse_pkg::ITER_W-1:0]        iteration_count,
	output logic [bse_pkg::CLS_W-1:0]         pixel_class,
	input  logic                              cfg_wr,
	input  logic [bse_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [bse_pkg::COORD_W-1:0]       cfg_wdata
);

	localparam int MAP_W = $bits(bse_pkg::map_item_t);
	localparam int RES_W = $bits(bse_pkg::res_item_t);

	// configuration registers
	logic [bse_pkg::COORD_W-1:0]        inv_scale_q;
	logic signed [bse_pkg::COORD_W-1:0] shift_real_q;
	logic signed [bse_pkg::COORD_W-1:0] shift_imag_q;
	logic [bse_pkg::ITER_W-1:0]         max_iter_q;

	// front to engine
	logic               mq_push;
	logic               mq_full;
	logic               mq_empty;
	logic               mq_pop;
	bse_pkg::map_item_t mq_wr_item;
	logic [MAP_W-1:0]   mq_rd_data;

	// engine to result queue
	logic               rq_push;
	logic               rq_full;
	bse_pkg::res_item_t rq_wr_item;
	logic [RES_W-1:0]   rq_rd_data;
	bse_pkg::res_item_t res_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_scale_q  <= bse_pkg::INV_SCALE_RST;
			shift_real_q <= '0;
			shift_imag_q <= '0;
			max_iter_q   <= bse_pkg::MAX_ITER_RST;
		end else if (cfg_wr) begin
			case (cfg_addr)
				bse_pkg::REG_INV_SCALE: inv_scale_q  <= cfg_wdata;
				bse_pkg::REG_SHIFT_RE:  shift_real_q <= cfg_wdata;
				bse_pkg::REG_SHIFT_IM:  shift_imag_q <= cfg_wdata;
				bse_pkg::REG_MAX_ITER:  max_iter_q   <= cfg_wdata[bse_pkg::ITER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// pixel to c mapping, one register stage
	bse_front #(
		.WIDTH  (WIDTH),
		.HEIGHT (HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.inv_scale  (inv_scale_q),
		.shift_real (shift_real_q),
		.shift_imag (shift_imag_q),
		.q_full     (mq_full),
		.q_push     (mq_push),
		.q_item     (mq_wr_item)
	);

	// decouples mapping from iteration
	bse_queue #(
		.W     (MAP_W),
		.DEPTH (bse_pkg::QUEUE_DEPTH)
	) u_map_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mq_push),
		.wr_data (mq_wr_item),
		.full    (mq_full),
		.rd_en   (mq_pop),
		.rd_data (mq_rd_data),
		.empty   (mq_empty)
	);

	// escape-time iteration
	bse_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.max_iter (max_iter_q),
		.in_valid (!mq_empty),
		.in_item  (bse_pkg::map_item_t'(mq_rd_data)),
		.in_pop   (mq_pop),
		.out_full (rq_full),
		.out_push (rq_push),
		.out_item (rq_wr_item)
	);

	// finished items wait here for the consumer
	bse_queue #(
		.W     (RES_W),
		.DEPTH (bse_pkg::QUEUE_DEPTH)
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rq_push),
		.wr_data (rq_wr_item),
		.full    (rq_full),
		.rd_en   (pop),
		.rd_data (rq_rd_data),
		.empty   (empty)
	);

	assign res_head        = bse_pkg::res_item_t'(rq_rd_data);
	assign out_x           = res_head.px;
	assign out_y           = res_head.py;
	assign iteration_count = res_head.count;
	assign pixel_class     = res_head.cls;

endmodule
